[rtl/core/seek_target_step_core_assert.svh]
// Assertion macros used by the controller of the seek step core.
`ifndef SEEK_TARGET_STEP_CORE_ASSERT_SVH
`define SEEK_TARGET_STEP_CORE_ASSERT_SVH
`ifndef SYNTH
// Checked while reset is released.
`define STS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("seek step core assertion failed");
// Checked on every clock edge, reset included.
`define STS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("seek step core assertion failed");
`else
`define STS_ASSERT(lbl, clk, rstn, prop)
`define STS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/core/sts_pkg.sv]
package sts_pkg;

  // Fixed-point formats.
  localparam int COORD_FRAC_BITS   = 4;
  localparam int HEADING_FRAC_BITS = 14;
  localparam int STEP_FRAC_BITS    = 8;
  localparam int LEN_EXTRA_BITS    = 8;
  localparam int STEP_SHIFT = HEADING_FRAC_BITS + STEP_FRAC_BITS - COORD_FRAC_BITS;

  // Unit heading and the short-vector fallback, round(0.01 * 2^14).
  localparam logic [15:0] HEAD_ONE      = 16'(1 << HEADING_FRAC_BITS);
  localparam logic [15:0] HEAD_FALLBACK = 16'(((1 << HEADING_FRAC_BITS) + 50) / 100);

  // Position after reset.
  localparam logic signed [15:0] START_RESET = 16'sd400;

  // Square root and divider widths.
  localparam int SQ_W   = 50;
  localparam int LEN_W  = 25;
  localparam int NUM_W  = 40;
  localparam int QUO_W  = 16;
  localparam int SQ_TOP = 48;

  // Register indexes.
  localparam logic CFG_START_X = 1'b0;
  localparam logic CFG_START_Y = 1'b1;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_DIVX_INIT,
    OP_DIVY_INIT,
    OP_DIVX,
    OP_DIVY,
    OP_MULX,
    OP_MULY,
    OP_STEPY,
    OP_FALLBACK,
    OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic moved;
  } cmd_t;

  typedef struct packed {
    logic zero_vec;
    logic sqrt_last;
    logic div_last;
  } status_t;

endpackage

[rtl/core/sts_datapath.sv]
module sts_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sts_pkg::cmd_t           cmd,
  input  logic signed [15:0]      target_x,
  input  logic signed [15:0]      target_y,
  input  logic [15:0]             step_length,
  output sts_pkg::status_t        status,
  output logic signed [15:0]      new_x,
  output logic signed [15:0]      new_y,
  output logic signed [15:0]      heading_x,
  output logic signed [15:0]      heading_y,
  output logic                    moved
);
  import sts_pkg::*;

  logic signed [15:0] tx_r, ty_r, pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic [15:0]        step_r;
  logic signed [16:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [15:0] hwx_r, hwy_r, lhx_r, lhy_r;
  logic signed [15:0] hwx_nxt, hwy_nxt, lhx_nxt, lhy_nxt;
  logic [31:0]        prod_r, prod_nxt;
  logic [32:0]        acc_r, acc_nxt;
  logic [SQ_W-1:0]    v_r, res_r, bit_r, v_nxt, res_nxt, bit_nxt, trial;
  logic [NUM_W-1:0]   num_r, dsh_r, num_nxt, dsh_nxt;
  logic [QUO_W-1:0]   q_r, q_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic signed [15:0] ox_r, oy_r, ohx_r, ohy_r, ox_nxt, oy_nxt, ohx_nxt, ohy_nxt;
  logic               om_r, om_nxt;
  logic [15:0]        mul_a, mul_b, mag_dx, mag_dy, mag_hx, mag_hy, mag_sel;
  logic               div_ge;
  logic [LEN_W-1:0]   len_s;
  logic [QUO_W-1:0]   q_clamp;
  logic signed [15:0] head_new;
  logic               neg_sel;
  logic signed [15:0] step_pos, step_sum_sat;
  logic               step_neg;
  logic [13:0]        delta;
  logic signed [17:0] step_sum;

  assign mag_dx = dx_r[16] ? 16'(-dx_r) : dx_r[15:0];
  assign mag_dy = dy_r[16] ? 16'(-dy_r) : dy_r[15:0];
  assign mag_hx = hwx_r[15] ? 16'(-hwx_r) : hwx_r;
  assign mag_hy = hwy_r[15] ? 16'(-hwy_r) : hwy_r;
  assign len_s  = res_r[LEN_W-1:0];

  // Shared multiplier operand select.
  always_comb begin
    unique case (cmd.op)
      OP_SQX:  begin mul_a = mag_dx; mul_b = mag_dx; end
      OP_SQY:  begin mul_a = mag_dy; mul_b = mag_dy; end
      OP_MULX: begin mul_a = mag_hx; mul_b = step_r; end
      OP_MULY: begin mul_a = mag_hy; mul_b = step_r; end
      default: begin mul_a = '0;     mul_b = '0;     end
    endcase
  end

  // Divider step and the rounded, clamped, signed quotient.
  always_comb begin
    div_ge   = (num_r >= dsh_r);
    q_nxt    = {q_r[QUO_W-2:0], div_ge};
    q_clamp  = (q_nxt > HEAD_ONE) ? HEAD_ONE : q_nxt;
    neg_sel  = (cmd.op == OP_DIVY) ? dy_r[16] : dx_r[16];
    head_new = neg_sel ? -$signed(q_clamp) : $signed(q_clamp);
  end

  // Step: round half away from zero, then add and saturate.
  always_comb begin
    step_neg = (cmd.op == OP_MULY) ? hwx_r[15] : hwy_r[15];
    step_pos = (cmd.op == OP_MULY) ? pos_x_r : pos_y_r;
    delta    = 14'((prod_r + 32'(1 << (STEP_SHIFT - 1))) >> STEP_SHIFT);
    step_sum = 18'(step_pos) + (step_neg ? -$signed({4'b0, delta}) : $signed({4'b0, delta}));
    if (step_sum > 18'sd32767) begin
      step_sum_sat = 16'sh7fff;
    end else if (step_sum < -18'sd32768) begin
      step_sum_sat = -16'sh8000;
    end else begin
      step_sum_sat = step_sum[15:0];
    end
  end

  // Register updates for each operation.
  always_comb begin
    pos_x_nxt = pos_x_r; pos_y_nxt = pos_y_r;
    dx_nxt = dx_r; dy_nxt = dy_r;
    hwx_nxt = hwx_r; hwy_nxt = hwy_r;
    lhx_nxt = lhx_r; lhy_nxt = lhy_r;
    prod_nxt = prod_r; acc_nxt = acc_r;
    v_nxt = v_r; res_nxt = res_r; bit_nxt = bit_r;
    num_nxt = num_r; dsh_nxt = dsh_r; cnt_nxt = cnt_r;
    ox_nxt = ox_r; oy_nxt = oy_r; ohx_nxt = ohx_r; ohy_nxt = ohy_r; om_nxt = om_r;
    trial = res_r + bit_r;
    mag_sel = (cmd.op == OP_DIVY_INIT) ? mag_dy : mag_dx;
    unique case (cmd.op)
      OP_LOAD: begin
        dx_nxt = 17'(target_x) - 17'(pos_x_r);
        dy_nxt = 17'(target_y) - 17'(pos_y_r);
      end
      OP_DIFF: begin
        dx_nxt = 17'(tx_r) - 17'(pos_x_r);
        dy_nxt = 17'(ty_r) - 17'(pos_y_r);
      end
      OP_SQX: prod_nxt = mul_a * mul_b;
      OP_SQY: begin
        prod_nxt = mul_a * mul_b;
        acc_nxt  = 33'(prod_r);
      end
      OP_SQRT_INIT: begin
        v_nxt   = SQ_W'(acc_r + 33'(prod_r)) << (2 * LEN_EXTRA_BITS);
        res_nxt = '0;
        bit_nxt = SQ_W'(1) << SQ_TOP;
      end
      OP_SQRT: begin
        if (v_r >= trial) begin
          v_nxt   = v_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end
      OP_DIVX_INIT, OP_DIVY_INIT: begin
        num_nxt = (NUM_W'(mag_sel) << (HEADING_FRAC_BITS + LEN_EXTRA_BITS))
                  + NUM_W'(len_s >> 1);
        dsh_nxt = NUM_W'(len_s) << (QUO_W - 1);
        cnt_nxt = 4'(QUO_W - 1);
      end
      OP_DIVX, OP_DIVY: begin
        if (div_ge) begin
          num_nxt = num_r - dsh_r;
        end
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == '0) begin
          if (cmd.op == OP_DIVX) begin
            hwx_nxt = head_new;
          end else begin
            hwy_nxt = head_new;
          end
        end
      end
      OP_MULX: prod_nxt = mul_a * mul_b;
      OP_MULY: begin
        prod_nxt  = mul_a * mul_b;
        pos_x_nxt = step_sum_sat;
      end
      OP_STEPY: pos_y_nxt = step_sum_sat;
      OP_FALLBACK: begin
        hwx_nxt = HEAD_FALLBACK;
        hwy_nxt = HEAD_FALLBACK;
      end
      OP_COMMIT: begin
        ox_nxt = pos_x_r;
        oy_nxt = pos_y_r;
        om_nxt = cmd.moved;
        if (cmd.moved) begin
          lhx_nxt = hwx_r; lhy_nxt = hwy_r;
          ohx_nxt = hwx_r; ohy_nxt = hwy_r;
        end else begin
          ohx_nxt = lhx_r; ohy_nxt = lhy_r;
        end
      end
      default: ;
    endcase
  end

  // Architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= START_RESET;
      pos_y_r <= START_RESET;
      lhx_r   <= '0;
      lhy_r   <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      lhx_r   <= lhx_nxt;
      lhy_r   <= lhy_nxt;
    end
  end

  // Working and output registers.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      tx_r   <= target_x;
      ty_r   <= target_y;
      step_r <= step_length;
    end
    dx_r <= dx_nxt; dy_r <= dy_nxt;
    hwx_r <= hwx_nxt; hwy_r <= hwy_nxt;
    prod_r <= prod_nxt; acc_r <= acc_nxt;
    v_r <= v_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
    num_r <= num_nxt; dsh_r <= dsh_nxt; cnt_r <= cnt_nxt; q_r <= q_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt; ohx_r <= ohx_nxt; ohy_r <= ohy_nxt; om_r <= om_nxt;
  end

  assign status.zero_vec  = (dx_r == '0) && (dy_r == '0);
  assign status.sqrt_last = bit_r[0];
  assign status.div_last  = (cnt_r == '0);

  assign new_x     = ox_r;
  assign new_y     = oy_r;
  assign heading_x = ohx_r;
  assign heading_y = ohy_r;
  assign moved     = om_r;

endmodule

[rtl/core/sts_ctrl.sv]
module sts_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sts_pkg::status_t status,
  output sts_pkg::cmd_t    cmd
);
  import sts_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE      = 17'h00001,
    ST_CHECK     = 17'h00002,
    ST_SQX       = 17'h00004,
    ST_SQY       = 17'h00008,
    ST_SQRT_INIT = 17'h00010,
    ST_SQRT      = 17'h00020,
    ST_DIVX_INIT = 17'h00040,
    ST_DIVX      = 17'h00080,
    ST_DIVY_INIT = 17'h00100,
    ST_DIVY      = 17'h00200,
    ST_MULX      = 17'h00400,
    ST_MULY      = 17'h00800,
    ST_STEPY     = 17'h01000,
    ST_LOAD2     = 17'h02000,
    ST_CHECK2    = 17'h04000,
    ST_FALLBACK  = 17'h08000,
    ST_DONE      = 17'h10000
  } state_t;

  state_t state_r, state_nxt;
  logic   pass2_r, pass2_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer: one request through difference, root, divide and step, then difference, root and divide again.
  always_comb begin
    state_nxt     = state_r;
    pass2_nxt     = pass2_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NOP;
    cmd.moved     = pass2_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          pass2_nxt = 1'b0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK:     state_nxt = status.zero_vec ? ST_DONE : ST_SQX;
      ST_SQX:       begin cmd.op = OP_SQX;       state_nxt = ST_SQY;       end
      ST_SQY:       begin cmd.op = OP_SQY;       state_nxt = ST_SQRT_INIT; end
      ST_SQRT_INIT: begin cmd.op = OP_SQRT_INIT; state_nxt = ST_SQRT;      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        if (status.sqrt_last) begin
          state_nxt = ST_DIVX_INIT;
        end
      end
      ST_DIVX_INIT: begin cmd.op = OP_DIVX_INIT; state_nxt = ST_DIVX; end
      ST_DIVX: begin
        cmd.op = OP_DIVX;
        if (status.div_last) begin
          state_nxt = ST_DIVY_INIT;
        end
      end
      ST_DIVY_INIT: begin cmd.op = OP_DIVY_INIT; state_nxt = ST_DIVY; end
      ST_DIVY: begin
        cmd.op = OP_DIVY;
        if (status.div_last) begin
          state_nxt = pass2_r ? ST_DONE : ST_MULX;
        end
      end
      ST_MULX:  begin cmd.op = OP_MULX;  state_nxt = ST_MULY;  end
      ST_MULY:  begin cmd.op = OP_MULY;  state_nxt = ST_STEPY; end
      ST_STEPY: begin cmd.op = OP_STEPY; state_nxt = ST_LOAD2; end
      ST_LOAD2: begin
        cmd.op    = OP_DIFF;
        pass2_nxt = 1'b1;
        state_nxt = ST_CHECK2;
      end
      ST_CHECK2:   state_nxt = status.zero_vec ? ST_FALLBACK : ST_SQX;
      ST_FALLBACK: begin cmd.op = OP_FALLBACK; state_nxt = ST_DONE; end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_COMMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass2_r     <= pass2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "seek_target_step_core_assert.svh"
  `STS_ASSERT(a_accept_starts, clk, rst_n, (in_valid && in_ready) |=> (state_r == ST_CHECK))
  `STS_ASSERT(a_root_to_div, clk, rst_n, (state_r == ST_SQRT && status.sqrt_last) |=> (state_r == ST_DIVX_INIT))
  `STS_ASSERT(a_result_from_done, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))

endmodule

[rtl/core/seek_target_step_core.sv]
// Walks a Q11.4 point one step per request toward a target and reports the
// new position and the Q1.14 unit heading from it to the target. A request
// that moves runs two square roots and four divisions on one shared unit set,
// or one root and two divisions when the step lands exactly on the target,
// plus multiply, step and sequencing states. A request already at the target
// goes from the check straight to the last state. A result that finds the
// output register still occupied waits in the last state until that register
// drains. One request is in work at a time. The next request can be taken in
// the cycle after its result is registered, while that result may still wait
// in the output register. The position resets to 400 and the cfg write port
// is left unconnected, so writes to the start registers are not visible.
module seek_target_step_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // target_x[15:0], target_y[31:16], step_length[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // new_x, new_y, heading_x, heading_y, moved[64], zeros
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import sts_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic signed [15:0] new_x, new_y, heading_x, heading_y;
  logic               moved;

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sts_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .target_x    (in_tdata[15:0]),
    .target_y    (in_tdata[31:16]),
    .step_length (in_tdata[47:32]),
    .status      (status),
    .new_x       (new_x),
    .new_y       (new_y),
    .heading_x   (heading_x),
    .heading_y   (heading_y),
    .moved       (moved)
  );

  assign out_tdata = {7'b0, moved, heading_y, heading_x, new_y, new_x};

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import sts_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 130;
  localparam logic signed [15:0] FALLBACK = 16'sd164;

  typedef struct packed {
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic signed [15:0] head_x;
    logic signed [15:0] head_y;
    logic               moved;
  } seek_result_t;

  typedef struct packed {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic [15:0]        step;
    logic               typed;
    seek_result_t       res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // target_x, target_y, step_length
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // new_x, new_y, heading_x, heading_y, moved, zeros
  logic        cfg_we = 1'b0;
  logic        cfg_addr = CFG_START_X;
  logic [15:0] cfg_wdata = '0;

  // Tracked block state; writes to the start registers have no effect.
  logic signed [15:0] trk_x = START_RESET;
  logic signed [15:0] trk_y = START_RESET;
  logic signed [15:0] trk_hx = '0;
  logic signed [15:0] trk_hy = '0;

  seek_result_t pending_moves[$];
  int errors = 0;
  int requests_taken = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always #6 clk = ~clk;

  seek_target_step_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  function automatic longint unsigned isqrt_u64(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] unit_comp(longint d, longint unsigned len_s);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? -d : d;
    q = ((mag << (HEADING_FRAC_BITS + LEN_EXTRA_BITS)) + (len_s >> 1)) / len_s;
    if (q > (64'd1 << HEADING_FRAC_BITS)) q = 64'd1 << HEADING_FRAC_BITS;
    return (d < 0) ? -16'(q) : 16'(q);
  endfunction

  // Unit heading from (px, py) toward (tx, ty); a near-zero vector falls back.
  task automatic unit_heading(input longint px, py, tx, ty,
                              output logic signed [15:0] hx, hy);
    longint dx;
    longint dy;
    longint unsigned len2;
    longint unsigned len_s;
    dx = tx - px;
    dy = ty - py;
    len2 = dx * dx + dy * dy;
    if (len2 * 10000 < (64'd1 << (2 * COORD_FRAC_BITS))) begin
      hx = FALLBACK;
      hy = FALLBACK;
    end else begin
      len_s = isqrt_u64(len2 << (2 * LEN_EXTRA_BITS));
      if (len_s == 0) len_s = 1;
      hx = unit_comp(dx, len_s);
      hy = unit_comp(dy, len_s);
    end
  endtask

  // Heading times step, rounded half away from zero into Q11.4.
  function automatic longint step_offset(logic signed [15:0] h, logic [15:0] step);
    longint unsigned mag;
    mag = ((h < 0) ? -longint'(h) : longint'(h)) * step;
    mag = (mag + (64'd1 << (STEP_SHIFT - 1))) >> STEP_SHIFT;
    return (h < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Advances the tracked state by one request and returns its result.
  task automatic seek_update(input logic signed [15:0] tx, ty, input logic [15:0] step,
                             output seek_result_t r);
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    r.moved = 1'b0;
    if (trk_x != tx || trk_y != ty) begin
      unit_heading(trk_x, trk_y, tx, ty, hx, hy);
      trk_x = sat16(longint'(trk_x) + step_offset(hx, step));
      trk_y = sat16(longint'(trk_y) + step_offset(hy, step));
      unit_heading(trk_x, trk_y, tx, ty, trk_hx, trk_hy);
      r.moved = 1'b1;
    end
    r.new_x = trk_x;
    r.new_y = trk_y;
    r.head_x = trk_hx;
    r.head_y = trk_hy;
  endtask

  // Offers one request and waits for it to be taken, then, unless quiet, sometimes drops valid for a random gap.
  task automatic send_request(input logic signed [15:0] tx, ty, input logic [15:0] step,
                              input bit typed, input seek_result_t typed_res);
    seek_result_t r;
    in_tdata <= {step, ty, tx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    seek_update(tx, ty, step, r);
    pending_moves.push_back(typed ? typed_res : r);
    requests_taken++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // The position never takes the written start values, so nothing is tracked here.
  task automatic write_reg(input logic addr, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random request: targets near the point in two ranges, some exact hits, some anywhere.
  task automatic random_request;
    int kind;
    int sk;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic [15:0] step;
    seek_result_t none;
    none = '0;
    kind = $urandom_range(0, 99);
    sk = $urandom_range(0, 99);
    if (kind < 10) begin
      tx = trk_x;
      ty = trk_y;
    end else if (kind < 55) begin
      tx = sat16(longint'(trk_x) + $signed($urandom_range(0, 128)) - 64);
      ty = sat16(longint'(trk_y) + $signed($urandom_range(0, 128)) - 64);
    end else if (kind < 75) begin
      tx = sat16(longint'(trk_x) + $signed($urandom_range(0, 4094)) - 2047);
      ty = sat16(longint'(trk_y) + $signed($urandom_range(0, 4094)) - 2047);
    end else begin
      tx = 16'($urandom);
      ty = 16'($urandom);
    end
    if (sk < 5) step = '0;
    else if (sk < 60) step = 16'($urandom_range(0, 1024));
    else if (sk < 85) step = 16'($urandom_range(0, 8191));
    else step = 16'($urandom);
    send_request(tx, ty, step, 1'b0, none);
  endtask

  // Directed requests: at target, exact landing, overshoot, extremes.
  dir_row_t dir_rows[12] = '{
    '{16'sd400, 16'sd400, 16'd300, 1'b1, '{16'sd400, 16'sd400, 16'sd0, 16'sd0, 1'b0}},
    '{16'sd416, 16'sd400, 16'd256, 1'b1, '{16'sd416, 16'sd400, FALLBACK, FALLBACK, 1'b1}},
    '{16'sd416, 16'sd400, 16'hffff, 1'b1,
      '{16'sd416, 16'sd400, FALLBACK, FALLBACK, 1'b0}},
    '{16'sd432, 16'sd400, 16'd512, 1'b0, '0},
    '{16'sd432, 16'sd400, 16'd0, 1'b0, '0},
    '{16'sh7fff, 16'sh7fff, 16'hffff, 1'b0, '0},
    '{16'sh7fff, 16'sh8000, 16'hffff, 1'b0, '0},
    '{16'sh8000, 16'sh8000, 16'hffff, 1'b0, '0},
    '{16'sh8000, 16'sh7fff, 16'd1, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'hffff, 1'b0, '0},
    '{-16'sd5, 16'sd3, 16'h8000, 1'b0, '0},
    '{16'sh5555, 16'shaaaa, 16'h00ff, 1'b0, '0}
  };

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result checking and the no-progress watchdog.
  always @(posedge clk) begin
    seek_result_t e;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_moves.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $realtime, out_tdata);
        errors++;
      end else begin
        e = pending_moves.pop_front();
        check_field("new_x", e.new_x, $signed(out_tdata[15:0]));
        check_field("new_y", e.new_y, $signed(out_tdata[31:16]));
        check_field("heading_x", e.head_x, $signed(out_tdata[47:32]));
        check_field("heading_y", e.head_y, $signed(out_tdata[63:48]));
        check_field("moved", e.moved, out_tdata[64]);
      end
    end
  end

  // Receiver: random stalls plus one long hold-off that backs up the input.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && requests_taken >= 600) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held = 1'b1;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus phases.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(CFG_START_X, 16'h8000);
    write_reg(CFG_START_Y, 16'h7fff);
    foreach (dir_rows[i])
      send_request(dir_rows[i].tx, dir_rows[i].ty, dir_rows[i].step,
                   dir_rows[i].typed, dir_rows[i].res);
    drain();
    write_reg(CFG_START_X, 16'h7fff);
    write_reg(CFG_START_Y, 16'h8000);
    repeat (600) random_request();
    drain();
    write_reg(CFG_START_X, 16'h0000);
    write_reg(CFG_START_Y, 16'hffff);
    repeat (500) random_request();
    drain();
    quiet = 1'b1;
    repeat (400) random_request();
    drain();
    if (errors == 0 && pending_moves.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sts_pkg.sv
rtl/core/sts_datapath.sv
rtl/core/sts_ctrl.sv
rtl/core/seek_target_step_core.sv
dv/testbench.sv
